FILE: rtl/per_source_sequence_table_macros.svh
// assertion macros used by the per-source sequence table checker
`ifndef PER_SOURCE_SEQUENCE_TABLE_MACROS_SVH
`define PER_SOURCE_SEQUENCE_TABLE_MACROS_SVH

// checked only while out of reset
`define PSS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PSS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pss_pkg.sv
// shared constants and types of the per-source sequence table
`default_nettype none

package pss_pkg;

    localparam int ENTRIES = 4;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W  = 48;
    localparam int SEQ_W   = 32;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             newly;
        logic             evicted;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/per_source_sequence_table.sv
// Per-source sequence table. Every input transaction gives exactly one result
// transaction, in order. A transaction is registered at the input, looked up and
// the table updated when it advances from the input register, and the result is
// shown from the output register, which out_valid follows. One transaction per
// cycle is sustained while out_stall is low: the combinational match and counter
// update of the table is the only loop, and the output register lets a new
// transaction in while a result waits on out_stall. The table is empty
// immediately after reset; no clearing pass is needed.
`default_nettype none

module per_source_sequence_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output wire logic                        in_stall,
    input  wire logic [pss_pkg::ADDR_W-1:0]  source_address,
    output wire logic                        out_valid,
    input  wire logic                        out_stall,
    output wire logic [pss_pkg::SEQ_W-1:0]   sequence_number,
    output wire logic                        newly_assigned,
    output wire logic                        evicted_other
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [pss_pkg::ADDR_W-1:0]  in_addr_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    pss_pkg::result_t            out_result_reg;
    pss_pkg::result_t            lookup_result;
    logic                        accept;
    logic                        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    pss_table u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .lookup_en      (advance),
        .lookup_address (in_addr_reg),
        .result         (lookup_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_addr_reg <= source_address;
        end
        if (advance)
        begin
            out_result_reg <= lookup_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sequence_number = out_result_reg.seq;
    assign newly_assigned  = out_result_reg.newly;
    assign evicted_other   = out_result_reg.evicted;

endmodule

`default_nettype wire

FILE: rtl/pss_table.sv
// source table: parallel match, free-entry pick, round-robin replacement, counter update
`default_nettype none

module pss_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        lookup_en,
    input  wire logic [pss_pkg::ADDR_W-1:0]  lookup_address,
    output pss_pkg::result_t                 result
);

    logic [pss_pkg::ENTRIES-1:0] valid_reg;
    logic [pss_pkg::ADDR_W-1:0]  addr_reg    [pss_pkg::ENTRIES];
    logic [pss_pkg::SEQ_W-1:0]   counter_reg [pss_pkg::ENTRIES];
    logic [pss_pkg::IDX_W-1:0]   victim_reg;
    logic [pss_pkg::IDX_W-1:0]   victim_next;

    logic [pss_pkg::ENTRIES-1:0] hit_vec;
    logic                        hit;
    logic [pss_pkg::SEQ_W-1:0]   hit_seq;
    logic [pss_pkg::SEQ_W-1:0]   hit_seq_inc;
    logic                        free_found;
    logic [pss_pkg::IDX_W-1:0]   free_idx;
    logic [pss_pkg::IDX_W-1:0]   alloc_idx;
    logic                        alloc;

    always_comb
    begin
        hit_seq  = '0;
        free_idx = '0;
        for (int i = 0; i < pss_pkg::ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (addr_reg[i] == lookup_address);
            hit_seq    = hit_seq | ({pss_pkg::SEQ_W{hit_vec[i]}} & counter_reg[i]);
        end
        for (int i = pss_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = pss_pkg::IDX_W'(i);
            end
        end
    end

    assign hit         = |hit_vec;
    assign hit_seq_inc = hit_seq + 1'b1;
    assign free_found  = ~&valid_reg;
    assign alloc_idx   = free_found ? free_idx : victim_reg;
    assign alloc       = lookup_en && !hit;

    // pointer wraps from the last entry back to zero
    assign victim_next = (victim_reg == pss_pkg::IDX_W'(pss_pkg::ENTRIES - 1))
                         ? '0 : victim_reg + 1'b1;

    assign result.seq     = hit ? hit_seq : '0;
    assign result.newly   = !hit;
    assign result.evicted = !hit && !free_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            victim_reg <= '0;
        end
        else if (alloc)
        begin
            valid_reg[alloc_idx] <= 1'b1;
            if (!free_found)
            begin
                victim_reg <= victim_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < pss_pkg::ENTRIES; i++)
        begin
            if (lookup_en && hit_vec[i])
            begin
                counter_reg[i] <= hit_seq_inc;
            end
            else if (alloc && (alloc_idx == pss_pkg::IDX_W'(i)))
            begin
                addr_reg[i]    <= lookup_address;
                counter_reg[i] <= pss_pkg::SEQ_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pss_checker.sv
// port-level checks of the per-source sequence table and their bind
`default_nettype none

`include "per_source_sequence_table_macros.svh"

module pss_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic [pss_pkg::ADDR_W-1:0]  source_address,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [pss_pkg::SEQ_W-1:0]   sequence_number,
    input wire logic                        newly_assigned,
    input wire logic                        evicted_other
);

    // no result can appear straight out of reset
    `PSS_ASSERT_ALWAYS(a_no_result_after_reset, clk, !rst_n |=> !out_valid, "result right after reset")

    // eviction only happens on an assignment
    `PSS_ASSERT(a_evict_implies_new, clk, rst_n, out_valid && evicted_other |-> newly_assigned, "eviction without assignment")

    // a fresh entry always starts its count at zero
    `PSS_ASSERT(a_new_starts_zero, clk, rst_n, out_valid && newly_assigned |-> sequence_number == '0, "new source with nonzero number")

    // a stalled result transaction holds
    `PSS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(sequence_number) && $stable(newly_assigned) && $stable(evicted_other), "stalled result changed")

endmodule

bind per_source_sequence_table pss_checker u_pss_checker (.*);

`default_nettype wire
